>>> rtl/core/bdst_pkg.sv
// shared types and constants for the bus device status table
`default_nettype none
package bdst_pkg;

   localparam int ENTRIES = 32;
   localparam int IDX_W = $clog2(ENTRIES);

   typedef enum logic [4:0] {
      CMD_CLEAR = 5'd0, CMD_FOUND = 5'd1, CMD_CONFIGURE = 5'd2, CMD_DELETE = 5'd3,
      CMD_SET_ERROR = 5'd4, CMD_SERIAL = 5'd5, CMD_ALARMS = 5'd6, CMD_CLASS = 5'd7,
      CMD_READ = 5'd8, CMD_NEXT_CONF = 5'd9, CMD_NEXT_PRESENT = 5'd10,
      CMD_PREV_PRESENT = 5'd11, CMD_NEXT_FREE = 5'd12, CMD_NEXT_CLASS = 5'd13,
      CMD_PRESENCE_MAP = 5'd14, CMD_ERROR_MAP = 5'd15, CMD_COUNT = 5'd16,
      CMD_ANY_ALARM = 5'd17, CMD_CLASS_ALARM = 5'd18
   } cmd_type;

   localparam logic [2:0] ST_NONE  = 3'd0;
   localparam logic [2:0] ST_FOUND = 3'd1;
   localparam logic [2:0] ST_CONF  = 3'd2;
   localparam logic [2:0] ST_OK    = 3'd3;
   localparam logic [2:0] ST_ERR   = 3'd4;

   typedef struct packed {
      logic [2:0]  status;
      logic [15:0] cls;
      logic [15:0] alarms;
      logic [15:0] serial;
   } entry_type;

   // control from sequencer into every cell
   typedef struct packed {
      logic        shift;     // rotate ring by one
      logic        clear;     // all status to none
      logic        write;     // write head cell
      entry_type   wdata;
   } cell_ctl_type;

   typedef enum logic [1:0] {S_IDLE, S_WALK, S_DONE} state_type;

endpackage
`default_nettype wire

>>> rtl/core/bus_device_status_table.sv
// Bus device status table: 32 slave entries kept in a rotating ring of cells.
// Requests arrive on req_ (tdata: cmd[4:0], address[12:5], operand_value[28:13],
// alarm_mask[36:29]); one response per request leaves on rsp_ (tdata: flag[0],
// result_address[8:1], status[11:9], class[27:12], alarms[43:28],
// serial[59:44], bitmap[92:60], count[98:93]).
// The ring turns one place per cycle unless a write holds it; cell 0 holds the
// entry currently in view. Every request makes one full turn of the ring, so
// an entry visited in turn is tested, read or rewritten as it passes the head
// cell; a write holds the ring while the head cell commits. After the turn
// each entry is back in its home cell.
// The response is registered as the control leaves the done state and returns
// to idle, where the next request can be taken while the response is valid;
// one request at a time.
// A held response does not block the input: one more request is taken and
// walked, then waits in the done state until rsp_tready frees the response.
// Reset empties the table (all status none, other fields zero) and
// the control returns to idle with no response pending.
`default_nettype none
module bus_device_status_table
   import bdst_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [39:0]  req_tdata,  // cmd, address, operand_value, alarm_mask
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [103:0]      rsp_tdata   // result_flag, result_address, entry_status,
                                         // entry_class, entry_alarms, entry_serial,
                                         // address_bitmap, present_count
);
   state_type   state_ff, state_in;
   logic [4:0]  cmd_ff, cmd_in;
   logic [7:0]  addr_ff, addr_in;
   logic [15:0] val_ff, val_in;
   logic [7:0]  mask_ff, mask_in;
   logic [IDX_W-1:0] pos_ff, pos_in;
   logic        flag_ff, flag_in;
   logic [7:0]  raddr_ff, raddr_in;
   entry_type   rd_ff, rd_in;
   logic [32:0] map_ff, map_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        hit_ff, hit_in;
   logic        rv_ff, rv_in;
   logic [103:0] rsp_ff, rsp_in;

   cell_ctl_type ctl;
   entry_type    ring [ENTRIES];
   entry_type    hd;

   for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
      bdst_cell u_cell (
         .clock(clock), .reset(reset), .ctl(ctl),
         .head(g == 0),
         .prev_entry(ring[(g + 1) % ENTRIES]),
         .entry(ring[g])
      );
   end

   assign hd = ring[0];

   logic       valid_a;
   logic [7:0] a;     // 1-based address of head entry
   logic       here, pres, match, hit;
   entry_type  wr;
   logic       do_wr, wflag;

   always_comb begin
      a = {{(8-IDX_W){1'b0}}, pos_ff} + 8'd1;
      valid_a = addr_ff >= 8'd1 && addr_ff <= 8'(ENTRIES);
      here = valid_a && a == addr_ff;
      pres = hd.status != ST_NONE;
      wr = hd;
      do_wr = 1'b0;
      wflag = 1'b0;
      case (cmd_ff)
         CMD_FOUND: if (hd.status == ST_NONE) begin
            wr.status = ST_FOUND; do_wr = 1'b1; wflag = 1'b1;
         end
         CMD_CONFIGURE: if (hd.status == ST_NONE || hd.status == ST_FOUND) begin
            wr.status = ST_CONF; do_wr = 1'b1; wflag = 1'b1;
         end
         CMD_DELETE: begin
            wr.status = ST_NONE; do_wr = 1'b1; wflag = 1'b1;
         end
         CMD_SET_ERROR: if (pres) begin
            wr.status = (val_ff != 16'd0) ? ST_ERR : ST_OK;
            do_wr = 1'b1; wflag = wr.status != hd.status;
         end
         CMD_SERIAL: if (pres) begin
            wr.serial = val_ff; do_wr = 1'b1; wflag = 1'b1;
         end
         CMD_ALARMS: if (pres) begin
            wr.alarms = val_ff; do_wr = 1'b1; wflag = hd.alarms != val_ff;
         end
         CMD_CLASS: begin
            wr.cls = val_ff; do_wr = 1'b1; wflag = 1'b1;
         end
         CMD_READ: wflag = pres;
         default: ;
      endcase
      case (cmd_ff)
         CMD_NEXT_CONF: match = hd.status == ST_OK || hd.status == ST_CONF ||
                                hd.status == ST_ERR;
         CMD_NEXT_PRESENT, CMD_PREV_PRESENT: match = pres;
         CMD_NEXT_FREE: match = !pres;
         CMD_NEXT_CLASS: match = pres && hd.cls == val_ff;
         default: match = 1'b0;
      endcase
      if (cmd_ff == CMD_PREV_PRESENT) hit = match && a < addr_ff;
      else hit = match && a > addr_ff;
   end

   always_comb begin
      state_in = state_ff;
      cmd_in = cmd_ff; addr_in = addr_ff; val_in = val_ff; mask_in = mask_ff;
      pos_in = pos_ff; flag_in = flag_ff; raddr_in = raddr_ff; rd_in = rd_ff;
      map_in = map_ff; cnt_in = cnt_ff; hit_in = hit_ff;
      rv_in = rv_ff; rsp_in = rsp_ff;
      ctl = '0;
      ctl.wdata = wr;
      req_tready = 1'b0;
      if (rv_ff && rsp_tready) rv_in = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd_in = req_tdata[4:0];
               addr_in = req_tdata[12:5];
               val_in = req_tdata[28:13];
               mask_in = req_tdata[36:29];
               pos_in = '0;
               flag_in = 1'b0; raddr_in = req_tdata[12:5]; rd_in = '0;
               map_in = '0; cnt_in = '0; hit_in = 1'b0;
               state_in = S_WALK;
            end
         end
         S_WALK: begin
            ctl.shift = 1'b1;
            case (cmd_ff)
               CMD_CLEAR: flag_in = 1'b1;
               CMD_FOUND, CMD_CONFIGURE, CMD_DELETE, CMD_SET_ERROR, CMD_SERIAL,
               CMD_ALARMS, CMD_CLASS, CMD_READ: if (here) begin
                  flag_in = wflag;
                  if (cmd_ff == CMD_READ) rd_in = hd;
                  if (do_wr) ctl.shift = 1'b0;
               end
               CMD_NEXT_CONF, CMD_NEXT_PRESENT, CMD_NEXT_FREE, CMD_NEXT_CLASS:
                  if (hit && !hit_ff) begin
                     hit_in = 1'b1; flag_in = 1'b1; raddr_in = a;
                  end
               CMD_PREV_PRESENT: if (hit) begin
                  flag_in = 1'b1; raddr_in = a;  // last hit below start wins
               end
               CMD_PRESENCE_MAP: begin
                  flag_in = 1'b1;
                  if (pres) map_in[a[5:0]] = 1'b1;
               end
               CMD_ERROR_MAP: begin
                  flag_in = 1'b1;
                  if (pres && (hd.status == ST_ERR || hd.alarms != 16'd0))
                     map_in[a[5:0]] = 1'b1;
               end
               CMD_COUNT: begin
                  flag_in = 1'b1;
                  if (pres) cnt_in = cnt_ff + 6'd1;
               end
               CMD_ANY_ALARM: if (pres && hd.alarms != 16'd0) flag_in = 1'b1;
               CMD_CLASS_ALARM:
                  if (pres && hd.cls == val_ff && (hd.alarms[7:0] & mask_ff) != 8'd0)
                     flag_in = 1'b1;
               default: ;
            endcase
            // a write holds the ring while the head cell commits, then rotation resumes
            if (!ctl.shift) begin
               ctl.write = 1'b1;
               addr_in = 8'd0;  // entry done; stop matching
            end else begin
               pos_in = pos_ff + 1'b1;
               if (pos_ff == IDX_W'(ENTRIES - 1)) state_in = S_DONE;
            end
         end
         S_DONE: begin
            // wait here while the previous response is still held
            if (!rv_ff || rsp_tready) begin
               if (cmd_ff == CMD_CLEAR) ctl.clear = 1'b1;
               rsp_in = {5'd0, cnt_ff, map_ff, rd_ff.serial, rd_ff.alarms, rd_ff.cls,
                         rd_ff.status,
                         (cmd_ff inside {[CMD_NEXT_CONF:CMD_NEXT_CLASS]}) ? raddr_ff
                                                                           : 8'd0,
                         flag_ff};
               rv_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rv_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rv_ff <= rv_in;
      end
      cmd_ff <= cmd_in; addr_ff <= addr_in; val_ff <= val_in; mask_ff <= mask_in;
      pos_ff <= pos_in; flag_ff <= flag_in; raddr_ff <= raddr_in; rd_ff <= rd_in;
      map_ff <= map_in; cnt_ff <= cnt_in; hit_ff <= hit_in; rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rv_ff;
   assign rsp_tdata = rsp_ff;
endmodule
`default_nettype wire

>>> rtl/core/bdst_cell.sv
// one table entry in the rotating ring of cells
`default_nettype none
module bdst_cell
   import bdst_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire cell_ctl_type ctl,
   input  wire logic         head,
   input  wire entry_type    prev_entry,
   output entry_type         entry
);
   entry_type entry_ff, entry_in;

   always_comb begin
      entry_in = entry_ff;
      if (ctl.shift) entry_in = prev_entry;
      else if (ctl.write && head) entry_in = ctl.wdata;
      if (ctl.clear) entry_in.status = ST_NONE;
   end

   always_ff @(posedge clock) begin
      if (reset) entry_ff <= '0;
      else entry_ff <= entry_in;
   end

   assign entry = entry_ff;
endmodule
`default_nettype wire
